[rtl/cvm_pkg.sv]
`default_nettype none

package cvm_pkg;

  localparam int COORD_W    = 32;
  localparam int SIZE_W     = 14;
  localparam int PROD_W     = COORD_W + 1 + SIZE_W;
  localparam int LANES      = 3;
  localparam int DIV_STAGES = COORD_W;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  localparam int IN_DATA_W  = 4 * COORD_W;
  localparam int OUT_DATA_W = LANES * COORD_W;
  localparam int OUT_USER_W = 2;

  localparam int REG_ADDR_W = 1;
  localparam logic [REG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [REG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd800;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd600;

  localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic               in_vol;
    logic               wzero;
    logic [LANES-1:0]   neg;
    logic [LANES-1:0]   ovf;
  } cvm_side_t;

  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] num;
    logic [COORD_W-1:0] quo;
  } cvm_lane_t;

  typedef struct packed {
    cvm_side_t                side;
    logic [COORD_W-1:0]       divisor;
    cvm_lane_t [LANES-1:0]    lane;
  } cvm_div_t;

endpackage

`default_nettype wire

[rtl/cvm_front.sv]
`default_nettype none

module cvm_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic signed [cvm_pkg::COORD_W-1:0]  clip_x,
  input  wire logic signed [cvm_pkg::COORD_W-1:0]  clip_y,
  input  wire logic signed [cvm_pkg::COORD_W-1:0]  clip_z,
  input  wire logic signed [cvm_pkg::COORD_W-1:0]  clip_w,
  input  wire logic        [cvm_pkg::SIZE_W-1:0]   screen_width,
  input  wire logic        [cvm_pkg::SIZE_W-1:0]   screen_height,
  output logic                                     out_valid,
  output cvm_pkg::cvm_div_t                        out_data
);
  import cvm_pkg::*;

  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int HIGH_W = NUM_W - COORD_W;

  // stage A: range test, sums, magnitudes of z and w
  logic signed [COORD_W:0] x_e, y_e, z_e, w_e, nw_e;
  logic signed [COORD_W:0] sum_x_next, sum_y_next;
  logic                    inside_next;
  logic [LANES-1:0]        neg_next;

  logic                    a_valid;
  logic signed [COORD_W:0] a_sum_x, a_sum_y;
  logic [COORD_W-1:0]      a_z_mag, a_w_mag;
  logic                    a_inside, a_wzero;
  logic [LANES-1:0]        a_neg;

  always_comb begin
    x_e  = {clip_x[COORD_W-1], clip_x};
    y_e  = {clip_y[COORD_W-1], clip_y};
    z_e  = {clip_z[COORD_W-1], clip_z};
    w_e  = {clip_w[COORD_W-1], clip_w};
    nw_e = -w_e;
    inside_next = !clip_z[COORD_W-1] && (z_e <= w_e) && (x_e >= nw_e) && (x_e <= w_e)
                  && (y_e >= nw_e) && (y_e <= w_e);
    sum_x_next = x_e + w_e;
    sum_y_next = w_e - y_e;
    neg_next[LANE_X] = sum_x_next[COORD_W] ^ clip_w[COORD_W-1];
    neg_next[LANE_Y] = sum_y_next[COORD_W] ^ clip_w[COORD_W-1];
    neg_next[LANE_Z] = clip_z[COORD_W-1] ^ clip_w[COORD_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sum_x  <= sum_x_next;
      a_sum_y  <= sum_y_next;
      a_z_mag  <= clip_z[COORD_W-1] ? (COORD_W'(0) - clip_z) : clip_z;
      a_w_mag  <= clip_w[COORD_W-1] ? (COORD_W'(0) - clip_w) : clip_w;
      a_inside <= inside_next;
      a_wzero  <= (clip_w == '0);
      a_neg    <= neg_next;
    end
  end

  // stage B: scale by viewport size
  logic [COORD_W:0]   mag_x, mag_y;
  logic               b_valid;
  logic [PROD_W-1:0]  b_prod_x, b_prod_y;
  logic [COORD_W-1:0] b_z_mag, b_w_mag;
  logic               b_inside, b_wzero;
  logic [LANES-1:0]   b_neg;

  always_comb begin
    mag_x = a_sum_x[COORD_W] ? ((COORD_W + 1)'(0) - a_sum_x) : a_sum_x;
    mag_y = a_sum_y[COORD_W] ? ((COORD_W + 1)'(0) - a_sum_y) : a_sum_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod_x <= PROD_W'(mag_x) * PROD_W'(screen_width);
      b_prod_y <= PROD_W'(mag_y) * PROD_W'(screen_height);
      b_z_mag  <= a_z_mag;
      b_w_mag  <= a_w_mag;
      b_inside <= a_inside;
      b_wzero  <= a_wzero;
      b_neg    <= a_neg;
    end
  end

  // stage C: dividend alignment, overflow check, first partial remainder
  logic [NUM_W-1:0]  num   [LANES];
  logic [HIGH_W-1:0] high  [LANES];
  cvm_div_t          c_next;

  always_comb begin
    num[LANE_X] = NUM_W'(b_prod_x) << (FRAC_BITS - 1);
    num[LANE_Y] = NUM_W'(b_prod_y) << (FRAC_BITS - 1);
    num[LANE_Z] = NUM_W'(b_z_mag) << FRAC_BITS;
    c_next.side.in_vol = b_inside;
    c_next.side.wzero  = b_wzero;
    c_next.side.neg    = b_neg;
    c_next.divisor     = b_w_mag;
    for (int i = 0; i < LANES; i++) begin
      high[i] = num[i][NUM_W-1:COORD_W];
      c_next.side.ovf[i] = NUM_W'(high[i]) >= NUM_W'(b_w_mag);
      c_next.lane[i].rem = c_next.side.ovf[i] ? '0 : COORD_W'(high[i]);
      c_next.lane[i].num = num[i][COORD_W-1:0];
      c_next.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= c_next;
    end
  end

endmodule

`default_nettype wire

[rtl/cvm_div_stage.sv]
`default_nettype none

module cvm_div_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire cvm_pkg::cvm_div_t in_data,
  output logic                   out_valid,
  output cvm_pkg::cvm_div_t      out_data
);
  import cvm_pkg::*;

  logic [COORD_W:0] trial [LANES];
  logic [COORD_W:0] diff  [LANES];
  cvm_div_t         step_next;

  // one restoring step per lane: bring in the next dividend bit
  always_comb begin
    step_next = in_data;
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {in_data.lane[i].rem, in_data.lane[i].num[COORD_W-1]};
      diff[i]  = trial[i] - {1'b0, in_data.divisor};
      step_next.lane[i].rem = diff[i][COORD_W] ? trial[i][COORD_W-1:0]
                                               : diff[i][COORD_W-1:0];
      step_next.lane[i].num = {in_data.lane[i].num[COORD_W-2:0], 1'b0};
      step_next.lane[i].quo = {in_data.lane[i].quo[COORD_W-2:0], !diff[i][COORD_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= step_next;
    end
  end

endmodule

`default_nettype wire

[rtl/cvm_back.sv]
`default_nettype none

module cvm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire cvm_pkg::cvm_div_t             in_data,
  output logic                               out_valid,
  output logic [cvm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [cvm_pkg::OUT_USER_W-1:0]     out_tuser
);
  import cvm_pkg::*;

  logic [COORD_W-1:0]    res [LANES];
  logic [COORD_W-1:0]    q;
  logic [OUT_DATA_W-1:0] data_next;

  // saturate, apply sign, force zero when w is zero
  always_comb begin
    data_next = '0;
    for (int i = 0; i < LANES; i++) begin
      q = in_data.lane[i].quo;
      if (in_data.side.wzero) begin
        res[i] = '0;
      end else if (in_data.side.neg[i]) begin
        res[i] = (in_data.side.ovf[i] || q[COORD_W-1]) ? SAT_NEG : (COORD_W'(0) - q);
      end else begin
        res[i] = (in_data.side.ovf[i] || q[COORD_W-1]) ? SAT_POS : q;
      end
      data_next[i*COORD_W +: COORD_W] = res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= data_next;
      out_tuser <= {in_data.side.wzero, in_data.side.in_vol};
    end
  end

endmodule

`default_nettype wire

[rtl/clip_test_and_viewport_map_core.sv]
`default_nettype none

// Pipeline from input transfer to result: 3 setup stages, 32 divide steps, 1 output stage.
// Throughput: one vertex per cycle unless m_tready stalls; each divide step stage resolves one
// quotient bit for all three divisions in parallel.
// Stall: the whole pipeline holds while a result waits on m_tready.
// Reset (rst, synchronous): clears all valid bits, screen_width to 800, screen_height to 600.
module clip_test_and_viewport_map_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [cvm_pkg::REG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [cvm_pkg::SIZE_W-1:0]         cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // clip_x, clip_y, clip_z, clip_w
  input  wire logic [cvm_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // screen_x, screen_y, depth_value
  output logic [cvm_pkg::OUT_DATA_W-1:0]          m_tdata,
  // inside_volume, w_was_zero
  output logic [cvm_pkg::OUT_USER_W-1:0]          m_tuser
);
  import cvm_pkg::*;

  logic [SIZE_W-1:0] screen_width, screen_height;
  logic              en;
  logic              div_valid [DIV_STAGES+1];
  cvm_div_t          div_data  [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  cvm_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s_tvalid),
    .clip_x        (s_tdata[0*COORD_W +: COORD_W]),
    .clip_y        (s_tdata[1*COORD_W +: COORD_W]),
    .clip_z        (s_tdata[2*COORD_W +: COORD_W]),
    .clip_w        (s_tdata[3*COORD_W +: COORD_W]),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (div_valid[0]),
    .out_data      (div_data[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    cvm_div_stage u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_valid[k]),
      .in_data   (div_data[k]),
      .out_valid (div_valid[k+1]),
      .out_data  (div_data[k+1])
    );
  end

  cvm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid[DIV_STAGES]),
    .in_data   (div_data[DIV_STAGES]),
    .out_valid (m_tvalid),
    .out_tdata (m_tdata),
    .out_tuser (m_tuser)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cvm_pkg::*;

  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 48;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] w;
  } vertex_t;

  typedef struct {
    logic               in_vol;
    logic               wzero;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] depth;
  } screen_pt_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [REG_ADDR_W-1:0] cfg_addr = REG_SCREEN_WIDTH;
  logic [SIZE_W-1:0]     cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  vertex_t    vertex_q[$];
  screen_pt_t screen_q[$];
  logic [SIZE_W-1:0] view_w = WIDTH_RESET;
  logic [SIZE_W-1:0] view_h = HEIGHT_RESET;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   in_wait = 0;
  int   out_wait = 0;
  bit   in_steady = 1'b0;
  bit   out_steady = 1'b0;
  int   idle_cycles = 0;
  int   errors = 0;
  vertex_t    next_v;
  screen_pt_t want;

  clip_test_and_viewport_map_core #(.FRAC_BITS(FRAC)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [COORD_W-1:0] scale_div(longint num, longint unsigned mult,
                                                   longint den);
    logic neg;
    longint unsigned a, d, q, r, lim, mag;
    neg = (num < 0) != (den < 0);
    a = longint'(num < 0 ? -num : num);
    a = a * mult;
    d = longint'(den < 0 ? -den : den);
    q = a / d;
    r = a % d;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > (64'd1 << (31 - FRAC))) begin
      mag = lim;
    end else begin
      mag = (q << FRAC) + (r << FRAC) / d;
      if (mag > lim) mag = lim;
    end
    if (neg) mag = 64'd0 - mag;
    return mag[COORD_W-1:0];
  endfunction

  function automatic screen_pt_t project_vertex(vertex_t v);
    screen_pt_t p;
    longint x, y, z, w;
    x = v.x;
    y = v.y;
    z = v.z;
    w = v.w;
    p.in_vol = z >= 0 && z <= w && x >= -w && x <= w && y >= -w && y <= w;
    p.wzero = (w == 0);
    if (w == 0) begin
      p.sx = '0;
      p.sy = '0;
      p.depth = '0;
    end else begin
      p.sx = scale_div(x + w, longint'(view_w), 2 * w);
      p.sy = scale_div(w - y, longint'(view_h), 2 * w);
      p.depth = scale_div(z, 1, w);
    end
    return p;
  endfunction

  function automatic vertex_t mk_vertex(longint x, longint y, longint z, longint w);
    vertex_t v;
    v.x = x[COORD_W-1:0];
    v.y = y[COORD_W-1:0];
    v.z = z[COORD_W-1:0];
    v.w = w[COORD_W-1:0];
    return v;
  endfunction

  function automatic longint pick(longint lo, longint hi);
    bit [63:0] r;
    r = {$urandom, $urandom};
    return lo + longint'(r % 64'(hi - lo + 1));
  endfunction

  function automatic vertex_t random_vertex();
    longint x, y, z, w;
    int kind;
    kind = $urandom_range(0, 9);
    w = pick(1, (longint'(1) <<< $urandom_range(1, 31)) - 1);
    x = pick(-w, w);
    y = pick(-w, w);
    z = pick(0, w);
    case (kind)
      0, 1, 2, 3, 4: begin
        if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 1) ? w : -w;
        if ($urandom_range(0, 7) == 0) y = $urandom_range(0, 1) ? w : -w;
        if ($urandom_range(0, 7) == 0) z = $urandom_range(0, 1) ? w : 0;
      end
      5: begin
        case ($urandom_range(0, 5))
          0: x = w + 1;
          1: x = -w - 1;
          2: y = w + 1;
          3: y = -w - 1;
          4: z = w + 1;
          default: z = -1;
        endcase
      end
      6: begin
        x = longint'(int'($urandom));
        y = longint'(int'($urandom));
        z = longint'(int'($urandom));
        w = longint'(int'($urandom));
      end
      7: begin
        w = pick(-4, 4);
        x = longint'(int'($urandom));
        y = longint'(int'($urandom));
        z = longint'(int'($urandom));
      end
      8: begin
        w = 0;
        x = $urandom_range(0, 1) ? 0 : pick(-3, 3);
        y = $urandom_range(0, 1) ? 0 : pick(-3, 3);
        z = $urandom_range(0, 1) ? 0 : pick(-3, 3);
      end
      default: begin
        w = -pick(1, longint'(1) <<< 31);
        x = pick(w, -w);
        y = pick(w, -w);
        z = pick(w, -w);
      end
    endcase
    return mk_vertex(x, y, z, w);
  endfunction

  task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
                                 input logic [COORD_W-1:0] exp_val);
    $display("mismatch %s: got %h, want %h at %0t", what, got, exp_val, $time);
    errors++;
  endtask

  task automatic settle();
    while (vertex_q.size() != 0 || s_tvalid || screen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_viewport(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_SCREEN_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_addr <= REG_SCREEN_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drive vertices
  always @(negedge clk) begin
    if (in_taken || !s_tvalid) begin
      if (in_wait > 0) begin
        in_wait--;
        s_tvalid <= 1'b0;
      end else if (vertex_q.size() != 0) begin
        next_v = vertex_q.pop_front();
        s_tdata <= {next_v.w, next_v.z, next_v.y, next_v.x};
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 31) == 0) in_steady = !in_steady;
        in_wait = in_steady ? 0 : $urandom_range(0, 19);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // stall the result side
  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 31) == 0) out_steady = !out_steady;
      out_wait = out_steady ? 0 : $urandom_range(0, 19);
    end
    if (out_wait > 0) begin
      out_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    out_taken <= !rst && m_tvalid && m_tready;
    if (cfg_we && !rst) begin
      if (cfg_addr == REG_SCREEN_WIDTH) view_w <= cfg_data;
      if (cfg_addr == REG_SCREEN_HEIGHT) view_h <= cfg_data;
    end
    if (!rst && s_tvalid && s_tready) begin
      screen_q.push_back(project_vertex(
        mk_vertex(longint'($signed(s_tdata[31:0])), longint'($signed(s_tdata[63:32])),
                  longint'($signed(s_tdata[95:64])), longint'($signed(s_tdata[127:96])))));
    end
    if (!rst && m_tvalid && m_tready) begin
      if (screen_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_tdata[31:0], '0);
      end else begin
        want = screen_q.pop_front();
        if (m_tuser[0] !== want.in_vol)
          report_mismatch("inside_volume", {31'd0, m_tuser[0]}, {31'd0, want.in_vol});
        if (m_tuser[1] !== want.wzero)
          report_mismatch("w_was_zero", {31'd0, m_tuser[1]}, {31'd0, want.wzero});
        if (m_tdata[31:0] !== want.sx) report_mismatch("screen_x", m_tdata[31:0], want.sx);
        if (m_tdata[63:32] !== want.sy) report_mismatch("screen_y", m_tdata[63:32], want.sy);
        if (m_tdata[95:64] !== want.depth)
          report_mismatch("depth_value", m_tdata[95:64], want.depth);
      end
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("clip_test_and_viewport_map_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int widths[8];
    int heights[8];
    widths = '{1, 8192, 0, 16383, 8192, 800, 0, 0};
    heights = '{1, 8192, 16383, 0, 1, 600, 0, 0};
    widths[6] = $urandom_range(1, 8192);
    heights[6] = $urandom_range(1, 8192);
    widths[7] = $urandom_range(0, 16383);
    heights[7] = $urandom_range(0, 16383);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    vertex_q.push_back(mk_vertex(0, 0, 0, 0));
    vertex_q.push_back(mk_vertex(1, 0, 0, 0));
    vertex_q.push_back(mk_vertex(0, 0, 0, 'h10000));
    vertex_q.push_back(mk_vertex('h10000, -'h10000, 'h10000, 'h10000));
    vertex_q.push_back(mk_vertex(-'h10000, 'h10000, 0, 'h10000));
    vertex_q.push_back(mk_vertex('h10001, 0, 'h8000, 'h10000));
    vertex_q.push_back(mk_vertex(0, -'h10001, 'h8000, 'h10000));
    vertex_q.push_back(mk_vertex(0, 0, -1, 'h10000));
    vertex_q.push_back(mk_vertex(0, 0, 'h10001, 'h10000));
    vertex_q.push_back(mk_vertex('h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF));
    vertex_q.push_back(mk_vertex(-'h80000000, -'h80000000, -'h80000000, -'h80000000));
    vertex_q.push_back(mk_vertex(0, 0, 0, -'h10000));
    vertex_q.push_back(mk_vertex('h7FFFFFFF, 0, 0, 1));
    vertex_q.push_back(mk_vertex(-'h80000000, 'h7FFFFFFF, 0, 1));
    vertex_q.push_back(mk_vertex(0, 0, -'h80000000, 1));
    vertex_q.push_back(mk_vertex(0, 0, 'h7FFFFFFF, -'h80000000));
    vertex_q.push_back(mk_vertex(0, 'h7FFFFFFF, 0, -1));
    vertex_q.push_back(mk_vertex(1, 2, 1, 3));
    vertex_q.push_back(mk_vertex(-1, -2, 2, 3));
    settle();

    for (int i = 0; i < 8; i++) begin
      set_viewport(SIZE_W'(widths[i]), SIZE_W'(heights[i]));
      repeat (62) vertex_q.push_back(random_vertex());
      settle();
    end

    if (errors == 0) begin
      $display("clip_test_and_viewport_map_core regression: pass");
    end else begin
      $display("clip_test_and_viewport_map_core regression: fail");
    end
    $finish;
  end

endmodule
